// File: src/assert_macros.svh
// Assertion helpers used by the conversion unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define C2S_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("c2s assertion failed");
`define C2S_ASSERT_ANY(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("c2s assertion failed");
`else
`define C2S_ASSERT(label, clk, rst_n, prop)
`define C2S_ASSERT_ANY(label, clk, prop)
`endif
`endif

// File: src/c2s_pkg.sv
package c2s_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int RHO_FRAC      = 8;
    localparam int ANG_FRAC      = 4;

    // square root datapath
    localparam int SQ_W        = 2 * COORD_WIDTH;
    localparam int SUM_W       = SQ_W + 1;
    localparam int RAD_W       = 2 * COORD_WIDTH + 2 * RHO_FRAC;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int REM_W       = ROOT_W + 2;
    localparam int SQRT_STAGES = ROOT_W;

    // CORDIC datapath
    localparam int DAT_W = ROOT_W + 4;
    localparam int ACC_W = 22;
    localparam int IDX_W = 5;
    localparam int ANG_W = 17;
    localparam int RAD_OUT_W = 16;
    localparam int POL_W = 16;

    // pipeline stage numbering
    localparam int PRE_STAGE = 2 + SQRT_STAGES;
    localparam int OUT_STAGE = PRE_STAGE + CORDIC_STAGES + 1;
    localparam int NUM_STAGES = OUT_STAGE + 1;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DAT_W-1:0]       t_dat;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [ANG_W-1:0]       t_ang;

    localparam t_acc HALF_PI_ACC = t_acc'(262144);
    localparam t_acc NEG_HALF_PI_ACC = t_acc'(-262144);
    localparam t_ang PI_OUT = t_ang'(32768);
    localparam t_ang NEG_PI_OUT = t_ang'(-32768);

    typedef struct packed {
        t_dat x;
        t_dat y;
        t_acc acc;
    } t_vec;

    // data that rides along with a point
    typedef struct packed {
        t_coord                 x;
        t_coord                 y;
        t_coord                 z;
        logic                   origin;
        logic                   xy_zero;
        logic [RAD_OUT_W-1:0]   radius;
    } t_side;

    // round(atan(2^-i) * 2^19 / pi)
    function automatic t_acc atan_entry(input logic [IDX_W-1:0] idx);
        t_acc a;
        case (idx)
            5'd0:  a = t_acc'(131072);
            5'd1:  a = t_acc'(77376);
            5'd2:  a = t_acc'(40884);
            5'd3:  a = t_acc'(20753);
            5'd4:  a = t_acc'(10417);
            5'd5:  a = t_acc'(5213);
            5'd6:  a = t_acc'(2607);
            5'd7:  a = t_acc'(1304);
            5'd8:  a = t_acc'(652);
            5'd9:  a = t_acc'(326);
            5'd10: a = t_acc'(163);
            5'd11: a = t_acc'(81);
            5'd12: a = t_acc'(41);
            5'd13: a = t_acc'(20);
            5'd14: a = t_acc'(10);
            5'd15: a = t_acc'(5);
            5'd16: a = t_acc'(3);
            5'd17: a = t_acc'(1);
            5'd18: a = t_acc'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

    // fold left half plane into right half, accumulator starts opposite
    function automatic t_vec pre_rotate(input t_dat x, input t_dat y);
        t_vec v;
        v.x   = x;
        v.y   = y;
        v.acc = '0;
        if (x[DAT_W-1]) begin
            if (!y[DAT_W-1]) begin
                v.x   = y;
                v.y   = -x;
                v.acc = HALF_PI_ACC;
            end else begin
                v.x   = -y;
                v.y   = x;
                v.acc = NEG_HALF_PI_ACC;
            end
        end
        return v;
    endfunction

    // floor((acc + 8) / 16), clamped to +/- pi
    function automatic t_ang final_angle(input t_acc acc);
        logic signed [ACC_W:0]          t;
        logic signed [ACC_W-ANG_FRAC:0] q;
        t_ang                           r;
        t = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (ANG_FRAC - 1));
        q = t[ACC_W:ANG_FRAC];
        if (q > (ACC_W-ANG_FRAC+1)'(PI_OUT)) begin
            r = PI_OUT;
        end else if (q < (ACC_W-ANG_FRAC+1)'(NEG_PI_OUT)) begin
            r = NEG_PI_OUT;
        end else begin
            r = q[ANG_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/c2s_sqrt_cell.sv
// One digit of a restoring square root: two radicand bits in, one root bit out
module c2s_sqrt_cell (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [c2s_pkg::RAD_W-1:0]    i_rad,
    input  logic [c2s_pkg::REM_W-1:0]    i_rem,
    input  logic [c2s_pkg::ROOT_W-1:0]   i_root,
    output logic [c2s_pkg::RAD_W-1:0]    o_rad,
    output logic [c2s_pkg::REM_W-1:0]    o_rem,
    output logic [c2s_pkg::ROOT_W-1:0]   o_root
);

    logic [c2s_pkg::RAD_W-1:0]  r_rad;
    logic [c2s_pkg::REM_W-1:0]  r_rem;
    logic [c2s_pkg::ROOT_W-1:0] r_root;
    logic [c2s_pkg::REM_W-1:0]  rem_sh;
    logic [c2s_pkg::REM_W:0]    diff;

    // trial subtract of 4*root+1 from the shifted remainder
    assign rem_sh = {i_rem[c2s_pkg::REM_W-3:0], i_rad[c2s_pkg::RAD_W-1 -: 2]};
    assign diff   = {1'b0, rem_sh} - {1'b0, i_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= {i_rad[c2s_pkg::RAD_W-3:0], 2'b00};
            if (!diff[c2s_pkg::REM_W]) begin
                r_rem  <= diff[c2s_pkg::REM_W-1:0];
                r_root <= {i_root[c2s_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {i_root[c2s_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;

endmodule

// File: src/c2s_cordic_cell.sv
// One CORDIC vectoring micro-rotation
module c2s_cordic_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [c2s_pkg::IDX_W-1:0]   i_stage,
    input  c2s_pkg::t_vec               i_vec,
    output c2s_pkg::t_vec               o_vec
);

    c2s_pkg::t_vec r_vec;
    c2s_pkg::t_dat dx;
    c2s_pkg::t_dat dy;
    c2s_pkg::t_acc ang;

    assign dx  = i_vec.y >>> i_stage;
    assign dy  = i_vec.x >>> i_stage;
    assign ang = c2s_pkg::atan_entry(i_stage);

    // steer by sign of y, zero counts as positive
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_vec.y[c2s_pkg::DAT_W-1]) begin
                r_vec.x   <= i_vec.x + dx;
                r_vec.y   <= i_vec.y - dy;
                r_vec.acc <= i_vec.acc + ang;
            end else begin
                r_vec.x   <= i_vec.x - dx;
                r_vec.y   <= i_vec.y + dy;
                r_vec.acc <= i_vec.acc - ang;
            end
        end
    end

    assign o_vec = r_vec;

endmodule

// File: src/cartesian_to_spherical_unit.sv
// Cartesian to spherical conversion, one point per beat.
// Input channel: i_in_valid / o_in_ready carry x, y, z (signed 16 bit).
// Output channel: o_out_valid / i_out_ready carry radius, polar angle
// (0..32768) and azimuth (-32768..32768), angles in units of pi/32768.
// Throughput: one point per clock while the output queue has room. Path from
// input beat to output beat: one squaring stage, one summing stage, 24 square-root
// digit cells, one pre-rotation stage, 16 CORDIC cells, one rounding stage and
// the write into the output queue.
// The square-root digit chain sets the depth.
// Radius and both angles run in one pipeline; the radius and polar angle use
// two root lanes, polar and azimuth use two CORDIC lanes side by side.
// A two-entry output queue sits after the pipeline; the pipeline and the
// input channel advance whenever the queue is not full, so input keeps
// flowing while one result waits on a stalled receiver.
// Reset clears the stage valid bits and the queue; no results are held.
module cartesian_to_spherical_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_x_coord,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_y_coord,
    input  logic signed [c2s_pkg::COORD_WIDTH-1:0] i_z_coord,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [c2s_pkg::RAD_OUT_W-1:0]        o_radius,
    output logic [c2s_pkg::POL_W-1:0]            o_polar_angle,
    output logic signed [c2s_pkg::ANG_W-1:0]     o_azimuth
);

`include "assert_macros.svh"

    localparam int NST = c2s_pkg::NUM_STAGES;
    localparam int PRE = c2s_pkg::PRE_STAGE;
    localparam int OUT = c2s_pkg::OUT_STAGE;
    localparam int NSQ = c2s_pkg::SQRT_STAGES;
    localparam int NCO = c2s_pkg::CORDIC_STAGES;

    logic               move;
    logic [NST-1:0]     r_v;
    c2s_pkg::t_side     r_side [OUT];
    c2s_pkg::t_side     side_org, side_rad;

    logic signed [c2s_pkg::SQ_W-1:0] sq_x, sq_y, sq_z;
    logic [c2s_pkg::SQ_W-1:0]  r_sq_x, r_sq_y, r_sq_z;
    logic [c2s_pkg::SUM_W-1:0] sum_xy, sum_all;

    // root lanes: 0 = radius, 1 = rho
    logic [c2s_pkg::RAD_W-1:0]  rad0 [NSQ+1];
    logic [c2s_pkg::REM_W-1:0]  rem0 [NSQ+1];
    logic [c2s_pkg::ROOT_W-1:0] root0 [NSQ+1];
    logic [c2s_pkg::RAD_W-1:0]  rad1 [NSQ+1];
    logic [c2s_pkg::REM_W-1:0]  rem1 [NSQ+1];
    logic [c2s_pkg::ROOT_W-1:0] root1 [NSQ+1];

    // CORDIC lanes: p = polar, a = azimuth
    c2s_pkg::t_vec vec_p [NCO+1];
    c2s_pkg::t_vec vec_a [NCO+1];
    c2s_pkg::t_vec r_pre_p, r_pre_a;

    logic [c2s_pkg::ROOT_W:0]    rnd_sum;
    logic [c2s_pkg::RAD_OUT_W-1:0] rnd_radius;
    c2s_pkg::t_dat               pol_x, pol_y, azi_x, azi_y;
    c2s_pkg::t_ang               ang_p, ang_a;

    logic [c2s_pkg::RAD_OUT_W-1:0] r_o_radius;
    logic [c2s_pkg::POL_W-1:0]     r_o_polar;
    c2s_pkg::t_ang                 r_o_azi;

    logic [c2s_pkg::RAD_OUT_W-1:0] r_q_radius [2];
    logic [c2s_pkg::POL_W-1:0]     r_q_polar [2];
    c2s_pkg::t_ang                 r_q_azi [2];
    logic                          r_wr_ptr, r_rd_ptr;
    logic [1:0]                    r_cnt;
    logic                          push, pop;

    // pipeline advances whenever the output queue has room
    assign move       = (r_cnt != 2'd2);
    assign o_in_ready = move;
    assign push       = move && r_v[OUT];
    assign pop        = o_out_valid && i_out_ready;

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (move) begin
            r_v <= {r_v[NST-2:0], i_in_valid};
        end
    end

    // sideband entries that pick up the origin flag and the radius
    always_comb begin
        side_org        = r_side[0];
        side_org.origin = (sum_all == '0);
        side_rad        = r_side[PRE-1];
        side_rad.radius = rnd_radius;
    end

    // sideband shift line
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_side[0].x       <= i_x_coord;
            r_side[0].y       <= i_y_coord;
            r_side[0].z       <= i_z_coord;
            r_side[0].xy_zero <= (i_x_coord == '0) && (i_y_coord == '0);
            r_side[0].origin  <= 1'b0;
            r_side[0].radius  <= '0;
            for (int k = 1; k < OUT; k++) begin
                if (k == 1) begin
                    r_side[k] <= side_org;
                end else if (k == PRE) begin
                    r_side[k] <= side_rad;
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    // squares
    assign sq_x = i_x_coord * i_x_coord;
    assign sq_y = i_y_coord * i_y_coord;
    assign sq_z = i_z_coord * i_z_coord;

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_sq_x <= $unsigned(sq_x);
            r_sq_y <= $unsigned(sq_y);
            r_sq_z <= $unsigned(sq_z);
        end
    end

    // sums and radicands
    assign sum_xy  = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign sum_all = sum_xy + {1'b0, r_sq_z};

    always_ff @(posedge i_clk) begin
        if (move) begin
            rad0[0] <= {{(c2s_pkg::RAD_W-c2s_pkg::SUM_W){1'b0}}, sum_all};
            rad1[0] <= {sum_xy[c2s_pkg::RAD_W-2*c2s_pkg::RHO_FRAC-1:0],
                        {(2*c2s_pkg::RHO_FRAC){1'b0}}};
        end
    end

    assign rem0[0]  = '0;
    assign root0[0] = '0;
    assign rem1[0]  = '0;
    assign root1[0] = '0;

    // square root digit chain
    for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
        c2s_sqrt_cell u_r (
            .i_clk  (i_clk),
            .i_en   (move),
            .i_rad  (rad0[k]),
            .i_rem  (rem0[k]),
            .i_root (root0[k]),
            .o_rad  (rad0[k+1]),
            .o_rem  (rem0[k+1]),
            .o_root (root0[k+1])
        );
        c2s_sqrt_cell u_rho (
            .i_clk  (i_clk),
            .i_en   (move),
            .i_rad  (rad1[k]),
            .i_rem  (rem1[k]),
            .i_root (root1[k]),
            .o_rad  (rad1[k+1]),
            .o_rem  (rem1[k+1]),
            .o_root (root1[k+1])
        );
    end

    // radius rounding: bump when remainder exceeds root, then saturate
    always_comb begin
        rnd_sum = {1'b0, root0[NSQ]} +
                  (c2s_pkg::ROOT_W+1)'(rem0[NSQ] > {2'b00, root0[NSQ]});
        if (rnd_sum > (c2s_pkg::ROOT_W+1)'({c2s_pkg::RAD_OUT_W{1'b1}})) begin
            rnd_radius = '1;
        end else begin
            rnd_radius = rnd_sum[c2s_pkg::RAD_OUT_W-1:0];
        end
    end

    // CORDIC operands and quadrant fold
    assign pol_x = c2s_pkg::t_dat'(r_side[PRE-1].z) <<< c2s_pkg::RHO_FRAC;
    assign pol_y = $signed({{(c2s_pkg::DAT_W-c2s_pkg::ROOT_W){1'b0}}, root1[NSQ]});
    assign azi_x = c2s_pkg::t_dat'(r_side[PRE-1].x);
    assign azi_y = c2s_pkg::t_dat'(r_side[PRE-1].y);

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_pre_p <= c2s_pkg::pre_rotate(pol_x, pol_y);
            r_pre_a <= c2s_pkg::pre_rotate(azi_x, azi_y);
        end
    end

    assign vec_p[0] = r_pre_p;
    assign vec_a[0] = r_pre_a;

    // CORDIC rotation chain
    for (genvar j = 0; j < NCO; j++) begin : g_cordic
        c2s_cordic_cell u_pol (
            .i_clk   (i_clk),
            .i_en    (move),
            .i_stage (c2s_pkg::IDX_W'(j)),
            .i_vec   (vec_p[j]),
            .o_vec   (vec_p[j+1])
        );
        c2s_cordic_cell u_azi (
            .i_clk   (i_clk),
            .i_en    (move),
            .i_stage (c2s_pkg::IDX_W'(j)),
            .i_vec   (vec_a[j]),
            .o_vec   (vec_a[j+1])
        );
    end

    // final rounding and special cases
    assign ang_p = c2s_pkg::final_angle(vec_p[NCO].acc);
    assign ang_a = c2s_pkg::final_angle(vec_a[NCO].acc);

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_o_radius <= r_side[OUT-1].radius;
            if (r_side[OUT-1].origin || ang_p[c2s_pkg::ANG_W-1]) begin
                r_o_polar <= '0;
            end else begin
                r_o_polar <= ang_p[c2s_pkg::POL_W-1:0];
            end
            if (r_side[OUT-1].origin || r_side[OUT-1].xy_zero) begin
                r_o_azi <= '0;
            end else begin
                r_o_azi <= ang_a;
            end
        end
    end

    // two-entry output queue
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_radius[r_wr_ptr] <= r_o_radius;
            r_q_polar[r_wr_ptr]  <= r_o_polar;
            r_q_azi[r_wr_ptr]    <= r_o_azi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assign o_out_valid   = (r_cnt != 2'd0);
    assign o_radius      = r_q_radius[r_rd_ptr];
    assign o_polar_angle = r_q_polar[r_rd_ptr];
    assign o_azimuth     = r_q_azi[r_rd_ptr];

    `C2S_ASSERT(a_queue_no_overflow, i_clk, i_rst_n, push |-> r_cnt != 2'd2)
    `C2S_ASSERT(a_ready_only_full, i_clk, i_rst_n, !o_in_ready |-> r_cnt == 2'd2)
    `C2S_ASSERT(a_polar_range, i_clk, i_rst_n, o_out_valid |-> o_polar_angle <= 16'd32768)
    `C2S_ASSERT(a_ptr_count, i_clk, i_rst_n, (r_cnt == 2'd1) |-> (r_wr_ptr != r_rd_ptr))

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LATENCY = 45;
    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_POINTS = 1000;
    localparam int RHO_SHIFT    = 8;

    typedef struct {
        logic [15:0]        radius;
        logic [15:0]        polar;
        logic signed [16:0] azimuth;
    } t_sph;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_x_coord = '0;
    logic signed [15:0] i_y_coord = '0;
    logic signed [15:0] i_z_coord = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [15:0]        o_radius;
    logic [15:0]        o_polar_angle;
    logic signed [16:0] o_azimuth;

    t_sph   pending_points[$];
    int     error_count = 0;
    int     idle_cycles = 0;

    cartesian_to_spherical_unit u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // exact integer square root, floor
    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // vectoring CORDIC, angle in pi/32768 units
    function automatic longint vector_angle(input longint yy, input longint xx);
        longint acc;
        longint tmp;
        longint dx;
        longint dy;
        longint ang;
        longint tab[19];
        tab = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
        acc = 0;
        if (xx == 0 && yy == 0) return 0;
        if (xx < 0) begin
            tmp = xx;
            if (yy >= 0) begin
                xx = yy; yy = -tmp; acc = 262144;
            end else begin
                xx = -yy; yy = tmp; acc = -262144;
            end
        end
        for (int i = 0; i < c2s_pkg::CORDIC_STAGES; i++) begin
            dx = yy >>> i;
            dy = xx >>> i;
            if (yy >= 0) begin
                xx += dx; yy -= dy; acc += (i < 19) ? tab[i] : 0;
            end else begin
                xx -= dx; yy += dy; acc -= (i < 19) ? tab[i] : 0;
            end
        end
        ang = (acc + 8) >>> 4;
        if (ang > 32768) ang = 32768;
        if (ang < -32768) ang = -32768;
        return ang;
    endfunction

    function automatic t_sph to_spherical(input longint x, input longint y, input longint z);
        t_sph               res;
        longint unsigned    sxy;
        longint unsigned    ssum;
        longint unsigned    r;
        longint             rho;
        longint             pol;
        longint             azi;
        sxy = x * x + y * y;
        ssum = sxy + z * z;
        r = int_sqrt(ssum);
        if (ssum - r * r > r) r++;
        if (r > 65535) r = 65535;
        if (ssum == 0) begin
            res.radius = '0; res.polar = '0; res.azimuth = '0;
            return res;
        end
        rho = int_sqrt(sxy << (2 * RHO_SHIFT));
        pol = vector_angle(rho, z <<< RHO_SHIFT);
        if (pol < 0) pol = 0;
        azi = vector_angle(y, x);
        res.radius  = r[15:0];
        res.polar   = pol[15:0];
        res.azimuth = azi[16:0];
        return res;
    endfunction

    // valid drops only when the next beat waits
    task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                              input logic signed [15:0] z);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_x_coord  <= x;
        i_y_coord  <= y;
        i_z_coord  <= z;
        i_in_valid <= 1'b1;
        pending_points.push_back(to_spherical(x, y, z));
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // receiver stall pattern, redrawn per beat
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 17);
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // result check against oldest expectation
    always @(posedge i_clk) begin
        t_sph want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_points.size() == 0) begin
                $error("unexpected beat radius=%0d", o_radius);
                error_count++;
            end else begin
                want = pending_points.pop_front();
                if (o_radius !== want.radius) begin
                    $error("radius exp %0d got %0d", want.radius, o_radius);
                    error_count++;
                end
                if (o_polar_angle !== want.polar) begin
                    $error("polar_angle exp %0d got %0d", want.polar, o_polar_angle);
                    error_count++;
                end
                if (o_azimuth !== want.azimuth) begin
                    $error("azimuth exp %0d got %0d", want.azimuth, o_azimuth);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // directed points: x, y, z, expected radius, polar, azimuth, known flag
    typedef struct {
        int  x, y, z;
        int  rad, pol, azi;
        bit  known;
    } t_row;

    t_row directed[] = '{
        '{0, 0, 0, 0, 0, 0, 1},
        '{0, 0, 1, 1, 0, 0, 1},
        '{0, 0, -1, 1, 32768, 0, 1},
        '{0, 0, 32767, 0, 0, 0, 0},
        '{0, 0, -32768, 0, 0, 0, 0},
        '{32767, 0, 0, 0, 0, 0, 0},
        '{-32768, 0, 0, 0, 0, 0, 0},
        '{0, 32767, 0, 0, 0, 0, 0},
        '{0, -32768, 0, 0, 0, 0, 0},
        '{-32768, -32768, -32768, 0, 0, 0, 0},
        '{32767, 32767, 32767, 0, 0, 0, 0},
        '{-32768, 32767, -32768, 0, 0, 0, 0},
        '{-1, 0, 0, 0, 0, 0, 0},
        '{-1, -1, 0, 0, 0, 0, 0},
        '{-1, 1, 0, 0, 0, 0, 0},
        '{1, -1, 1, 0, 0, 0, 0},
        '{3, 4, 12, 0, 0, 0, 0},
        '{-5, 0, 1, 0, 0, 0, 0},
        '{1, 1, -32768, 0, 0, 0, 0}
    };

    initial begin
        t_row row;
        t_sph known_res;
        int   sel;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            row = directed[k];
            send_point(16'(row.x), 16'(row.y), 16'(row.z));
            if (row.known) begin
                // typed-in value replaces the predicted one
                known_res.radius  = 16'(row.rad);
                known_res.polar   = 16'(row.pol);
                known_res.azimuth = 17'(row.azi);
                pending_points[$] = known_res;
            end
        end

        for (int n = 0; n < RANDOM_POINTS; n++) begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: send_point(16'($urandom_range(0, 15) - 8), 16'($urandom_range(0, 15) - 8),
                              16'($urandom_range(0, 15) - 8));
                1: send_point(16'd0, 16'd0, 16'($urandom));
                2: send_point(16'($urandom), 16'($urandom), 16'd0);
                default: send_point(16'($urandom), 16'($urandom), 16'($urandom));
            endcase
        end
        i_in_valid <= 1'b0;

        while (pending_points.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/c2s_pkg.sv
src/c2s_sqrt_cell.sv
src/c2s_cordic_cell.sv
src/cartesian_to_spherical_unit.sv
tb/sv/tb_top.sv
